// File: sv/bhc_pkg.sv
package bhc_pkg;

  localparam logic [15:0] DefaultPeriod = 16'd4199;
  localparam int unsigned ThrottleFull = 255;

  // phase order in low-side masks: bit0 A, bit1 B, bit2 C
  typedef logic [2:0] phase_mask_t;
  typedef logic [5:0] gates_t;

  // hall code to gate pattern of its six-step state, codes 0 and 7 give all off
  function automatic gates_t hall_gates(input logic [2:0] hall);
    gates_t g;
    unique case (hall)
      3'd1:    g = 6'h12;  // step 1: C high, A low
      3'd2:    g = 6'h09;  // step 3: A high, B low
      3'd3:    g = 6'h18;  // step 2: C high, B low
      3'd4:    g = 6'h24;  // step 5: B high, C low
      3'd5:    g = 6'h06;  // step 6: B high, A low
      3'd6:    g = 6'h21;  // step 4: A high, C low
      default: g = 6'h00;
    endcase
    return g;
  endfunction

  // hall code to the phase that is pulled low, its duty goes to zero
  function automatic phase_mask_t hall_low_phase(input logic [2:0] hall);
    phase_mask_t m;
    unique case (hall)
      3'd1, 3'd5: m = 3'b001;
      3'd2, 3'd3: m = 3'b010;
      3'd4, 3'd6: m = 3'b100;
      default:    m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// File: sv/bldc_hall_commutator.sv
// ch   dir  handshake            payload
// cfg  in   cfg_write            cfg_data (pwm_period)
// in   in   in_valid/in_stall    throttle_write, throttle_value, hall_bits, fault_active
// out  out  out_valid/out_stall  gate_enables, duty_phase_a/b/c, fault_led, run_led, fault_total
//
// one transaction per cycle while out_stall does not hold the result; a transaction is
// registered in the input register, then the commutation logic (one 8x16 multiply and a
// divide by 255) feeds the result registers, which hold the motor state itself.
// rst is synchronous and clears state; pwm_period returns to 4199.
// in_stall rises only while the result register is full and out_stall is high.
module bldc_hall_commutator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        throttle_write,
  input  logic [7:0]  throttle_value,
  input  logic [2:0]  hall_bits,
  input  logic        fault_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  gate_enables,
  output logic [15:0] duty_phase_a,
  output logic [15:0] duty_phase_b,
  output logic [15:0] duty_phase_c,
  output logic        fault_led,
  output logic        run_led,
  output logic [15:0] fault_total
);

  logic [15:0] pwm_period;

  // input register
  logic       s1_valid;
  logic       s1_write;
  logic [7:0] s1_value;
  logic [2:0] s1_hall;
  logic       s1_fault;

  // motor state, shown directly as the result
  logic [7:0]  target_throttle;
  logic        running_flag;
  logic [2:0]  previous_hall;
  logic        previous_hall_valid;
  logic [5:0]  gate_state;
  logic [15:0] phase_duty_a;
  logic [15:0] phase_duty_b;
  logic [15:0] phase_duty_c;
  logic [15:0] fault_counter;
  logic        fault_flag;
  logic        result_valid;

  logic advance;

  assign advance  = s1_valid && (!result_valid || !out_stall);
  assign in_stall = s1_valid && result_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= bhc_pkg::DefaultPeriod;
    end else if (cfg_write) begin
      pwm_period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_write <= throttle_write;
      s1_value <= throttle_value;
      s1_hall  <= hall_bits;
      s1_fault <= fault_active;
    end
  end

  // next state
  logic [7:0]  throttle;
  logic        hall_change;
  logic [23:0] product;
  logic [24:0] est_sum;
  logic [16:0] quot_est;
  logic [24:0] quot_times;
  logic [24:0] remainder;
  logic [15:0] duty;
  logic [5:0]  step_gates;
  logic [2:0]  low_mask;
  logic [7:0]  target_throttle_next;
  logic        running_flag_next;
  logic [5:0]  gate_state_next;
  logic [15:0] phase_duty_a_next;
  logic [15:0] phase_duty_b_next;
  logic [15:0] phase_duty_c_next;
  logic [15:0] fault_counter_next;

  always_comb begin
    throttle    = s1_write ? s1_value : target_throttle;
    hall_change = !previous_hall_valid || (s1_hall != previous_hall);

    // duty = throttle * period / 255, estimate from x*257/65536 then fix up
    product    = {16'd0, throttle} * {8'd0, pwm_period};
    est_sum    = {1'b0, product} + {9'd0, product[23:8]};
    quot_est   = est_sum[24:8];
    quot_times = {quot_est, 8'd0} - {8'd0, quot_est};
    remainder  = {1'b0, product} - quot_times;
    if (remainder >= 25'(2 * bhc_pkg::ThrottleFull)) begin
      duty = quot_est[15:0] + 16'd2;
    end else if (remainder >= 25'(bhc_pkg::ThrottleFull)) begin
      duty = quot_est[15:0] + 16'd1;
    end else begin
      duty = quot_est[15:0];
    end

    if (throttle == 8'd0) begin
      step_gates = 6'd0;
      low_mask   = 3'd0;
    end else begin
      step_gates = bhc_pkg::hall_gates(s1_hall);
      low_mask   = bhc_pkg::hall_low_phase(s1_hall);
    end

    target_throttle_next = throttle;
    running_flag_next    = throttle != 8'd0;
    gate_state_next      = gate_state;
    phase_duty_a_next    = phase_duty_a;
    phase_duty_b_next    = phase_duty_b;
    phase_duty_c_next    = phase_duty_c;
    fault_counter_next   = fault_counter;

    if (s1_fault || (throttle == 8'd0 && running_flag)) begin
      gate_state_next   = 6'd0;
      phase_duty_a_next = 16'd0;
      phase_duty_b_next = 16'd0;
      phase_duty_c_next = 16'd0;
    end else if (hall_change || (throttle != 8'd0 && !running_flag)) begin
      gate_state_next   = step_gates;
      phase_duty_a_next = low_mask[0] ? 16'd0 : duty;
      phase_duty_b_next = low_mask[1] ? 16'd0 : duty;
      phase_duty_c_next = low_mask[2] ? 16'd0 : duty;
    end

    if (s1_fault) begin
      target_throttle_next = 8'd0;
      fault_counter_next   = fault_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid        <= 1'b0;
      target_throttle     <= 8'd0;
      running_flag        <= 1'b0;
      previous_hall       <= 3'd0;
      previous_hall_valid <= 1'b0;
      gate_state          <= 6'd0;
      phase_duty_a        <= 16'd0;
      phase_duty_b        <= 16'd0;
      phase_duty_c        <= 16'd0;
      fault_counter       <= 16'd0;
      fault_flag          <= 1'b0;
    end else if (advance) begin
      result_valid        <= 1'b1;
      target_throttle     <= target_throttle_next;
      running_flag        <= running_flag_next;
      previous_hall       <= s1_hall;
      previous_hall_valid <= 1'b1;
      gate_state          <= gate_state_next;
      phase_duty_a        <= phase_duty_a_next;
      phase_duty_b        <= phase_duty_b_next;
      phase_duty_c        <= phase_duty_c_next;
      fault_counter       <= fault_counter_next;
      fault_flag          <= s1_fault;
    end else if (!out_stall) begin
      result_valid <= 1'b0;
    end
  end

  assign out_valid    = result_valid;
  assign gate_enables = gate_state;
  assign duty_phase_a = phase_duty_a;
  assign duty_phase_b = phase_duty_b;
  assign duty_phase_c = phase_duty_c;
  assign fault_led    = fault_flag;
  assign run_led      = target_throttle != 8'd0;
  assign fault_total  = fault_counter;

endmodule

// File: sv/bhc_checker.sv
module bhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  gate_enables,
  input logic [15:0] duty_phase_a,
  input logic [15:0] duty_phase_b,
  input logic [15:0] duty_phase_c,
  input logic        fault_led,
  input logic        run_led
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input side only backs up behind a stalled full result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the result register");

  // a faulted transaction shows everything off
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fault_led |-> gate_enables == 6'd0 && !run_led &&
      duty_phase_a == 16'd0 && duty_phase_b == 16'd0 && duty_phase_c == 16'd0)
    else $error("fault transaction with live gates or duty");

  // no gate without a throttle target
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_led |-> gate_enables == 6'd0)
    else $error("gates enabled with zero throttle");

  // either all off or exactly one high side and one low side
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(gate_enables) == 0 || $countones(gate_enables) == 2)
    else $error("illegal gate pattern");

endmodule

bind bldc_hall_commutator bhc_checker u_bhc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .gate_enables (gate_enables),
  .duty_phase_a (duty_phase_a),
  .duty_phase_b (duty_phase_b),
  .duty_phase_c (duty_phase_c),
  .fault_led    (fault_led),
  .run_led      (run_led)
);

// File: bench/bldc_hall_commutator_tb.sv
module bldc_hall_commutator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_NONE} phase_t;

  typedef struct {
    bhc_pkg::gates_t gates;
    logic [15:0]     duty_a;
    logic [15:0]     duty_b;
    logic [15:0]     duty_c;
    logic            fault_led;
    logic            run_led;
    logic [15:0]     fault_total;
  } drive_t;

  // indexed by hall code, code 0 in the low bits
  localparam logic [47:0] GATES_BY_HALL =
    {6'h00, 6'h21, 6'h06, 6'h24, 6'h18, 6'h09, 6'h12, 6'h00};
  localparam logic [15:0] LOW_BY_HALL =
    {PH_NONE, PH_C, PH_A, PH_C, PH_B, PH_B, PH_A, PH_NONE};
  // forward rotation: hall 1, 3, 2, 6, 4, 5
  localparam logic [17:0] HALL_ORDER = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};

  logic            clk;
  logic            rst;
  logic            cfg_write;
  logic [15:0]     cfg_data;
  logic            in_valid;
  logic            in_stall;
  logic            throttle_write;
  logic [7:0]      throttle_value;
  logic [2:0]      hall_bits;
  logic            fault_active;
  logic            out_valid;
  logic            out_stall;
  bhc_pkg::gates_t gate_enables;
  logic [15:0]     duty_phase_a;
  logic [15:0]     duty_phase_b;
  logic [15:0]     duty_phase_c;
  logic            fault_led;
  logic            run_led;
  logic [15:0]     fault_total;

  // motor state as the block should hold it
  logic [15:0]     period_reg;
  logic [7:0]      target_thr;
  logic            spinning;
  logic [2:0]      last_hall;
  logic            last_hall_seen;
  bhc_pkg::gates_t gate_state;
  logic [15:0]     duty_state [3];
  logic [15:0]     fault_count;

  drive_t      drive_queue [$];
  int          mismatch_count = 0;
  bit          sender_gaps = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_request = 0;
  int          hall_pos = 0;

  bldc_hall_commutator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .throttle_write (throttle_write),
    .throttle_value (throttle_value),
    .hall_bits      (hall_bits),
    .fault_active   (fault_active),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .gate_enables   (gate_enables),
    .duty_phase_a   (duty_phase_a),
    .duty_phase_b   (duty_phase_b),
    .duty_phase_c   (duty_phase_c),
    .fault_led      (fault_led),
    .run_led        (run_led),
    .fault_total    (fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void drive_phases(logic [2:0] hall, logic [7:0] thr);
    logic [15:0] duty;
    phase_t low;
    duty = 16'((32'(thr) * 32'(period_reg)) / bhc_pkg::ThrottleFull);
    for (int p = 0; p < 3; p++) duty_state[p] = duty;
    if (thr == 8'd0) begin
      gate_state = '0;
    end else begin
      gate_state = GATES_BY_HALL[hall*6 +: 6];
      low = phase_t'(LOW_BY_HALL[hall*2 +: 2]);
      if (low != PH_NONE) duty_state[low] = '0;
    end
  endfunction

  function automatic drive_t step_motor(logic wr, logic [7:0] tv, logic [2:0] hall,
                                        logic fault);
    drive_t d;
    if (wr) target_thr = tv;
    if (!last_hall_seen || hall != last_hall) begin
      last_hall = hall;
      last_hall_seen = 1'b1;
      drive_phases(hall, target_thr);
    end
    // kickstart on a target rising from zero, cut on a drop to zero
    if (target_thr != 8'd0 && !spinning) drive_phases(hall, target_thr);
    else if (target_thr == 8'd0 && spinning) drive_phases(hall, 8'd0);
    spinning = (target_thr != 8'd0);
    // fault leaves the running flag set
    if (fault) begin
      fault_count = fault_count + 16'd1;
      target_thr = 8'd0;
      drive_phases(hall, 8'd0);
    end
    d.gates = gate_state;
    d.duty_a = duty_state[PH_A];
    d.duty_b = duty_state[PH_B];
    d.duty_c = duty_state[PH_C];
    d.fault_led = fault;
    d.run_led = (target_thr != 8'd0);
    d.fault_total = fault_count;
    return d;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    drive_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, got gates %h",
                   $time, gate_enables);
          mismatch_count++;
        end else begin
          want = drive_queue.pop_front();
          compare_field("gate_enables", 16'(want.gates), 16'(gate_enables));
          compare_field("duty_phase_a", want.duty_a, duty_phase_a);
          compare_field("duty_phase_b", want.duty_b, duty_phase_b);
          compare_field("duty_phase_c", want.duty_c, duty_phase_c);
          compare_field("fault_led", 16'(want.fault_led), 16'(fault_led));
          compare_field("run_led", 16'(want.run_led), 16'(run_led));
          compare_field("fault_total", want.fault_total, fault_total);
        end
      end
      if (in_valid && !in_stall)
        drive_queue.push_back(step_motor(throttle_write, throttle_value, hall_bits,
                                         fault_active));
    end
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  initial begin : receiver
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  task automatic send_sample(logic wr, logic [7:0] tv, logic [2:0] hall, logic fault);
    int gap;
    in_valid <= 1'b1;
    throttle_write <= wr;
    throttle_value <= tv;
    hall_bits <= hall;
    fault_active <= fault;
    do @(posedge clk); while (in_stall);
    gap = (sender_gaps && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic input_idle();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (drive_queue.size() != 0);
  endtask

  task automatic set_period(logic [15:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    period_reg = value;
  endtask

  // mostly proper hall rotation, some off codes and some random jumps
  task automatic random_sample();
    int roll;
    logic [2:0] hall;
    logic [7:0] tv;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) hall_pos = (hall_pos + 1) % 6;
      else if (roll >= 8) hall_pos = (hall_pos + 5) % 6;
      hall = HALL_ORDER[hall_pos*3 +: 3];
    end else if (roll < 80) begin
      hall = ($urandom_range(0, 1) == 1) ? 3'd7 : 3'd0;
    end else begin
      hall = 3'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 10) tv = 8'd0;
    else if (roll < 20) tv = 8'd255;
    else tv = 8'($urandom);
    send_sample($urandom_range(0, 99) < 15, tv, hall, $urandom_range(0, 99) < 3);
  endtask

  task automatic test_directed();
    send_sample(1'b0, 8'hAA, 3'd0, 1'b0);  // first sample commutates with no target
    send_sample(1'b1, 8'd255, 3'd1, 1'b0); // kickstart at full throttle
    send_sample(1'b0, 8'h55, 3'd3, 1'b0);
    send_sample(1'b0, 8'h55, 3'd2, 1'b0);
    send_sample(1'b0, 8'h55, 3'd6, 1'b0);
    send_sample(1'b0, 8'h55, 3'd4, 1'b0);
    send_sample(1'b0, 8'h55, 3'd5, 1'b0);
    send_sample(1'b0, 8'h00, 3'd5, 1'b0);  // same code, nothing changes
    send_sample(1'b0, 8'h00, 3'd7, 1'b0);  // invalid code, gates off, all duties full
    send_sample(1'b0, 8'h00, 3'd0, 1'b0);
    send_sample(1'b1, 8'd1, 3'd1, 1'b0);
    send_sample(1'b1, 8'd0, 3'd1, 1'b0);   // drop to zero cuts the gates
    send_sample(1'b1, 8'd200, 3'd1, 1'b0); // kickstart on same code
    send_sample(1'b0, 8'd0, 3'd1, 1'b1);
    send_sample(1'b1, 8'd90, 3'd1, 1'b0);  // flag still set, motor waits
    send_sample(1'b0, 8'd0, 3'd3, 1'b0);
    send_sample(1'b1, 8'd255, 3'd2, 1'b1); // write and fault together
    send_sample(1'b0, 8'd0, 3'd2, 1'b0);   // clears the stale running flag
    send_sample(1'b1, 8'd60, 3'd2, 1'b0);
    send_sample(1'b0, 8'd0, 3'd0, 1'b1);
    send_sample(1'b1, 8'd255, 3'd7, 1'b0);
    send_sample(1'b0, 8'hFF, 3'd6, 1'b0);  // value ignored without write
    input_idle();
  endtask

  task automatic test_period_extremes();
    set_period(16'hFFFF);
    send_sample(1'b1, 8'd255, 3'd2, 1'b0);
    send_sample(1'b1, 8'd254, 3'd6, 1'b0);
    send_sample(1'b1, 8'd1, 3'd4, 1'b0);
    input_idle();
    set_period(16'd1);
    send_sample(1'b1, 8'd255, 3'd5, 1'b0);
    send_sample(1'b1, 8'd254, 3'd1, 1'b0);
    send_sample(1'b1, 8'd128, 3'd3, 1'b0);
    input_idle();
    set_period(16'd0);
    send_sample(1'b1, 8'd255, 3'd2, 1'b0);
    send_sample(1'b0, 8'd0, 3'd6, 1'b1);
    send_sample(1'b1, 8'd77, 3'd4, 1'b0);
    input_idle();
    set_period(bhc_pkg::DefaultPeriod);
  endtask

  task automatic test_input_backpressure();
    wait_drained();
    sender_gaps = 1'b0;
    stalls_on = 1'b0;
    hold_request = 200;
    for (int n = 0; n < 40; n++) random_sample();
    input_idle();
    wait_drained();
    sender_gaps = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [15:0] periods [6];
    periods = '{bhc_pkg::DefaultPeriod, 16'd1, 16'hFFFF, 16'd0,
                16'($urandom_range(2, 65534)), 16'($urandom)};
    for (int p = 0; p < 6; p++) begin
      set_period(periods[p]);
      // one phase runs back to back with no idling on either side
      sender_gaps = (p != 4);
      stalls_on = (p != 4);
      repeat (246) random_sample();
      input_idle();
    end
    sender_gaps = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    throttle_write <= 1'b0;
    throttle_value <= '0;
    hall_bits <= '0;
    fault_active <= 1'b0;
    period_reg = bhc_pkg::DefaultPeriod;
    target_thr = '0;
    spinning = 1'b0;
    last_hall = '0;
    last_hall_seen = 1'b0;
    gate_state = '0;
    for (int p = 0; p < 3; p++) duty_state[p] = '0;
    fault_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_period_extremes();
    test_input_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
